// ----- rtl/rmq_pkg.sv -----
// Shared types and codes for the range argmin query unit.
// Depends on nothing; used by rmq_cell and range_argmin_query_unit.
package rmq_pkg;

    localparam int POS_BITS = 4;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } rmq_cmd_t;

    // Query token handed from cell to cell; the running best value travels beside it.
    typedef struct packed {
        logic                valid;
        logic                err;
        logic                have;
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] last;
        logic [POS_BITS-1:0] idx;
    } rmq_tok_t;

endpackage

// ----- rtl/rmq_cell.sv -----
// One element cell of the query chain: holds one stored value and one token stage.
// Depends on rmq_pkg.
module rmq_cell #(
    parameter int CELL_IDX   = 0,
    parameter int VALUE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                wr_en,
    input  logic [rmq_pkg::POS_BITS-1:0]        wr_addr,
    input  logic signed [VALUE_BITS-1:0]        wr_val,
    input  rmq_pkg::rmq_tok_t                   tok_in,
    input  logic signed [VALUE_BITS-1:0]        best_in,
    output rmq_pkg::rmq_tok_t                   tok_out,
    output logic signed [VALUE_BITS-1:0]        best_out
);

    localparam bit REACH = CELL_IDX < (1 << rmq_pkg::POS_BITS);
    localparam logic [rmq_pkg::POS_BITS-1:0] MY_IDX = rmq_pkg::POS_BITS'(CELL_IDX);

    logic signed [VALUE_BITS-1:0] elem_reg;
    rmq_pkg::rmq_tok_t            tok_reg, tok_next;
    logic signed [VALUE_BITS-1:0] best_reg, best_next;
    logic                         in_rng;
    logic                         take;

    always_ff @(posedge aclk) begin
        if (wr_en && REACH && (wr_addr == MY_IDX)) begin
            elem_reg <= wr_val;
        end
    end

    // later index wins on ties: replace unless the best so far is strictly smaller
    always_comb begin
        in_rng    = REACH && (MY_IDX >= tok_in.start) && (MY_IDX <= tok_in.last);
        take      = tok_in.valid && !tok_in.err && in_rng
                    && (!tok_in.have || !(best_in < elem_reg));
        tok_next  = tok_in;
        best_next = best_in;
        if (take) begin
            tok_next.have = 1'b1;
            tok_next.idx  = MY_IDX;
            best_next     = elem_reg;
        end
    end

    // only the valid bit is reset; the rest of the stage is plain data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            tok_reg.valid <= tok_next.valid;
        end
        if (adv) begin
            tok_reg.err   <= tok_next.err;
            tok_reg.have  <= tok_next.have;
            tok_reg.start <= tok_next.start;
            tok_reg.last  <= tok_next.last;
            tok_reg.idx   <= tok_next.idx;
            best_reg      <= best_next;
        end
    end

    assign tok_out  = tok_reg;
    assign best_out = best_reg;

endmodule

// ----- rtl/range_argmin_query_unit.sv -----
// Range argmin query unit: write items load elements, query items return the argmin index.
// A write lands in the addressed cell's element register with no result. A query token is
// captured by cell 0 at the transfer edge, then passes through each remaining cell register
// and then the output register, which raises m_valid.
// Throughput: one query in flight at a time; writes 1/cycle while no query is in flight.
// Reset (aresetn, sync, active low) clears the chain tokens, busy flag and output valid;
// the element store has no reset and is undefined until written.
// Depends on rmq_pkg and rmq_cell.
module range_argmin_query_unit #(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [3:0]         s_position,
    input  logic [3:0]         s_range_end,
    input  logic signed [15:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_min_index,
    output logic               m_range_error
);

    // largest index a query may reach, clamped to what the position field can address
    localparam logic [3:0] LAST_MAX = (ENTRIES - 1 > 15) ? 4'd15 : 4'(ENTRIES - 1);

    rmq_pkg::rmq_tok_t            tok  [ENTRIES+1];
    logic signed [VALUE_BITS-1:0] bval [ENTRIES+1];
    logic [ENTRIES-1:0]           tok_valid_vec;

    logic                         busy_reg, busy_next;
    logic                         out_valid_reg, out_valid_next;
    logic [3:0]                   out_idx_reg;
    logic                         out_err_reg;

    logic                         in_xfer;
    logic                         wr_en;
    logic                         q_xfer;
    logic [3:0]                   last_clamped;
    logic signed [VALUE_BITS-1:0] wr_val;
    logic                         out_free;
    logic                         adv;
    logic                         tail_move;

    // One query in flight at a time; writes are taken whenever no query is running.
    assign s_ready = !busy_reg;
    assign in_xfer = s_valid && s_ready;
    assign wr_en   = in_xfer && (s_command == rmq_pkg::CMD_WRITE);
    assign q_xfer  = in_xfer && (s_command == rmq_pkg::CMD_QUERY);

    // sign-extend or cut the 16-bit value to the stored width
    assign wr_val = VALUE_BITS'(s_value);

    assign last_clamped = (s_range_end > LAST_MAX) ? LAST_MAX : s_range_end;

    // Token injected at the head of the chain. An error query still walks the chain
    // so every result leaves through the same tail; cells ignore errored tokens.
    always_comb begin
        tok[0].valid = q_xfer;
        tok[0].err   = s_position > last_clamped;
        tok[0].have  = 1'b0;
        tok[0].start = s_position;
        tok[0].last  = last_clamped;
        tok[0].idx   = '0;
        bval[0]      = '0;
    end

    // Output register decouples the chain from the result channel; the chain only
    // stalls when a finished token sits at the tail and the output is still full.
    assign out_free  = !out_valid_reg || m_ready;
    assign tail_move = tok[ENTRIES].valid && out_free;
    assign adv       = !tok[ENTRIES].valid || out_free;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        rmq_cell #(
            .CELL_IDX  (g),
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .wr_en   (wr_en),
            .wr_addr (s_position),
            .wr_val  (wr_val),
            .tok_in  (tok[g]),
            .best_in (bval[g]),
            .tok_out (tok[g+1]),
            .best_out(bval[g+1])
        );
        assign tok_valid_vec[g] = tok[g+1].valid;
    end

    always_comb begin
        busy_next = busy_reg;
        if (q_xfer) begin
            busy_next = 1'b1;
        end else if (tail_move) begin
            busy_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = tok[ENTRIES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tail_move) begin
            out_idx_reg <= tok[ENTRIES].idx;
            out_err_reg <= tok[ENTRIES].err;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_min_index   = out_idx_reg;
    assign m_range_error = out_err_reg;

    // at most one query token anywhere in the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tok_valid_vec) <= 1)
        else $error("more than one query token in the chain");

    // no token may be in flight while the unit reports idle
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (tok_valid_vec == '0))
        else $error("token in chain while not busy");

    // a query transfer marks the unit busy and enters the head cell
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_xfer |=> (busy_reg && tok[1].valid))
        else $error("query transfer did not start the chain");

    // an error result always carries index zero
    a_err_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_range_error) |-> (m_min_index == 4'd0))
        else $error("range error with nonzero index");

endmodule
